/* hw/rtl/nflp_pkg.sv */
`timescale 1ns / 1ps
package nflp_pkg;

	localparam int NODES  = 16;
	localparam int GROUPS = 8;
	localparam int NODE_W = 4;
	localparam int GRP_W  = 3;
	localparam int LOAD_W = 16;
	localparam int TIME_W = 32;
	localparam int CFG_W  = 48;
	localparam int CIDX_W = 3;

	localparam logic [CIDX_W-1:0] CFG_TIMEOUT  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_MAX_LOAD = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_GROUPS   = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_NODE_GRP = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_REPORT   = 3'd4;

	localparam logic [1:0] OP_HEARTBEAT = 2'd0;
	localparam logic [1:0] OP_TICK      = 2'd1;
	localparam logic [1:0] OP_LOOKUP    = 2'd2;

	localparam logic [1:0] KIND_REPORT   = 2'd0;
	localparam logic [1:0] KIND_ASSIGN   = 2'd1;
	localparam logic [1:0] KIND_REDIRECT = 2'd2;
	localparam logic [1:0] KIND_NONE     = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [3:0]        node;
		logic [15:0]       load;
		logic [31:0]       now;
		logic signed [31:0] user_hash;
	} nflp_req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] node_out;
		logic       alive_out;
		logic [2:0] group_out;
		logic       last;
	} nflp_res_t;

	typedef enum logic [1:0] {
		SEL_HB,
		SEL_ASSIGN,
		SEL_REPORT,
		SEL_LOOKUP
	} nflp_sel_t;

	typedef struct packed {
		logic      capture;
		logic      hb_write;
		logic      eval;
		logic      idx_inc;
		logic      tgt_node;
		logic      tgt_rem;
		logic      scan_clr;
		logic      scan_step;
		logic      set_primary;
		logic      mod_step;
		logic      emit;
		nflp_sel_t sel;
		logic      flush;
	} nflp_cmd_t;

	typedef struct packed {
		logic known_i;
		logic prim_dead;
		logic hb_assign;
		logic idx_last;
		logic scan_last;
		logic pick_found;
		logic mod_last;
		logic report_en;
		logic pend_valid;
		logic res_valid;
	} nflp_stat_t;

	function automatic logic [GRP_W-1:0] group_of(logic [CFG_W-1:0] ng,
			logic [NODE_W-1:0] i);
		return ng[int'(i) * GRP_W +: GRP_W];
	endfunction

endpackage

/* hw/rtl/nflp_ctrl.sv */
`timescale 1ns / 1ps
module nflp_ctrl import nflp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] op,
	output logic       busy,
	input  nflp_stat_t stat,
	output nflp_cmd_t  cmd
);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_HB     = 13'b0000000000010,
		S_T_EVAL = 13'b0000000000100,
		S_T_CHK  = 13'b0000000001000,
		S_T_SCAN = 13'b0000000010000,
		S_T_PICK = 13'b0000000100000,
		S_T_REP  = 13'b0000001000000,
		S_T_NEXT = 13'b0000010000000,
		S_L_MOD  = 13'b0000100000000,
		S_L_TGT  = 13'b0001000000000,
		S_L_SCAN = 13'b0010000000000,
		S_L_EMIT = 13'b0100000000000,
		S_FIN    = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.sel = SEL_HB;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					case (op)
						OP_HEARTBEAT: state_d = S_HB;
						OP_TICK:      state_d = S_T_EVAL;
						OP_LOOKUP:    state_d = S_L_MOD;
						default:      state_d = S_FIN;
					endcase
				end
			end
			S_HB: begin
				cmd.hb_write = 1'b1;
				cmd.emit = stat.hb_assign;
				cmd.sel = SEL_HB;
				state_d = S_FIN;
			end
			S_T_EVAL: begin
				if (stat.known_i) begin
					cmd.eval = 1'b1;
					state_d = S_T_CHK;
				end else begin
					state_d = S_T_NEXT;
				end
			end
			S_T_CHK: begin
				if (stat.prim_dead) begin
					cmd.tgt_node = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = S_T_SCAN;
				end else begin
					cmd.emit = stat.report_en;
					cmd.sel = SEL_REPORT;
					state_d = S_T_NEXT;
				end
			end
			S_T_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_T_PICK;
				end
			end
			S_T_PICK: begin
				if (stat.pick_found) begin
					cmd.set_primary = 1'b1;
					cmd.emit = 1'b1;
					cmd.sel = SEL_ASSIGN;
					state_d = S_T_REP;
				end else begin
					state_d = S_T_NEXT;
				end
			end
			S_T_REP: begin
				cmd.emit = stat.report_en;
				cmd.sel = SEL_REPORT;
				state_d = S_T_NEXT;
			end
			S_T_NEXT: begin
				if (stat.idx_last) begin
					state_d = S_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_T_EVAL;
				end
			end
			S_L_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					state_d = S_L_TGT;
				end
			end
			S_L_TGT: begin
				cmd.tgt_rem = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d = S_L_SCAN;
			end
			S_L_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_L_EMIT;
				end
			end
			S_L_EMIT: begin
				cmd.emit = 1'b1;
				cmd.sel = SEL_LOOKUP;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.flush = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !stat.pend_valid)
		else $error("result held while idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request not taken");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_valid |-> $past(busy))
		else $error("result without request");

endmodule

/* hw/rtl/nflp_dp.sv */
`timescale 1ns / 1ps
module nflp_dp import nflp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  nflp_req_t         req,
	input  logic              cfg_valid,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              cfg_ready,
	input  nflp_cmd_t         cmd,
	output nflp_stat_t        stat,
	output logic              result_valid,
	output nflp_res_t         result
);

	logic [15:0]       timeout_q;
	logic [15:0]       max_load_q;
	logic [3:0]        group_count_q;
	logic [CFG_W-1:0]  node_groups_q;
	logic              report_q;

	logic [NODES-1:0]  known_q;
	logic [NODES-1:0]  alive_q;
	logic [TIME_W-1:0] stamp_q [NODES];
	logic [LOAD_W-1:0] load_q [NODES];
	logic [GROUPS-1:0] pv_q;
	logic [NODE_W-1:0] pn_q [GROUPS];

	nflp_req_t         req_q;
	logic [NODE_W-1:0] idx_q;
	logic [NODE_W-1:0] scan_q;
	logic [LOAD_W-1:0] best_q;
	logic [NODE_W-1:0] pick_q;
	logic              found_q;
	logic [GRP_W-1:0]  tgt_q;
	logic [31:0]       mag_q;
	logic [2:0]        rem_q;
	logic [4:0]        mod_cnt_q;

	nflp_res_t pend_q;
	logic      pend_v_q;
	nflp_res_t res_q;
	logic      res_v_q;

	logic [GRP_W-1:0]  grp_hb;
	logic [GRP_W-1:0]  grp_i;
	logic [GRP_W-1:0]  grp_j;
	logic signed [32:0] age;
	logic              dead;
	logic [3:0]        gc_eff;
	logic [3:0]        rem_x;
	logic [3:0]        rem_n;
	logic [31:0]       mag_in;
	nflp_res_t         new_res;

	assign cfg_ready = 1'b1;

	assign grp_hb = group_of(node_groups_q, req_q.node);
	assign grp_i  = group_of(node_groups_q, idx_q);
	assign grp_j  = group_of(node_groups_q, scan_q);

	assign age  = $signed({1'b0, req_q.now}) - $signed({1'b0, stamp_q[idx_q]});
	assign dead = age > $signed({17'b0, timeout_q});

	always_comb begin
		if (group_count_q == 4'd0) begin
			gc_eff = 4'd1;
		end else if (group_count_q > 4'(GROUPS)) begin
			gc_eff = 4'(GROUPS);
		end else begin
			gc_eff = group_count_q;
		end
	end

	assign rem_x  = {rem_q, mag_q[31]};
	assign rem_n  = (rem_x >= gc_eff) ? (rem_x - gc_eff) : rem_x;
	assign mag_in = req.user_hash[31] ? (32'd0 - req.user_hash) : req.user_hash;

	always_comb begin
		new_res = '0;
		case (cmd.sel)
			SEL_HB: begin
				new_res.kind = KIND_ASSIGN;
				new_res.node_out = req_q.node;
				new_res.group_out = grp_hb;
			end
			SEL_ASSIGN: begin
				new_res.kind = KIND_ASSIGN;
				new_res.node_out = pick_q;
				new_res.group_out = tgt_q;
			end
			SEL_REPORT: begin
				new_res.kind = KIND_REPORT;
				new_res.node_out = idx_q;
				new_res.alive_out = alive_q[idx_q];
			end
			SEL_LOOKUP: begin
				new_res.kind = found_q ? KIND_REDIRECT : KIND_NONE;
				new_res.node_out = found_q ? pick_q : '0;
				new_res.group_out = tgt_q;
			end
			default: new_res = '0;
		endcase
	end

	always_comb begin
		stat = '0;
		stat.known_i    = known_q[idx_q];
		stat.prim_dead  = pv_q[grp_i] && (pn_q[grp_i] == idx_q) && !alive_q[idx_q];
		stat.hb_assign  = !pv_q[grp_hb];
		stat.idx_last   = (idx_q == NODE_W'(NODES - 1));
		stat.scan_last  = (scan_q == NODE_W'(NODES - 1));
		stat.pick_found = found_q;
		stat.mod_last   = (mod_cnt_q == 5'd31);
		stat.report_en  = report_q;
		stat.pend_valid = pend_v_q;
		stat.res_valid  = res_v_q;
	end

	// configuration and table flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= 16'd4;
			max_load_q    <= 16'd100;
			group_count_q <= 4'd1;
			node_groups_q <= '0;
			report_q      <= 1'b0;
			known_q       <= '0;
			alive_q       <= '0;
			pv_q          <= '0;
			pend_v_q      <= 1'b0;
			res_v_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_TIMEOUT:  timeout_q <= cfg_data[15:0];
					CFG_MAX_LOAD: max_load_q <= cfg_data[15:0];
					CFG_GROUPS:   group_count_q <= cfg_data[3:0];
					CFG_NODE_GRP: node_groups_q <= cfg_data;
					CFG_REPORT:   report_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.hb_write) begin
				known_q[req_q.node] <= 1'b1;
				alive_q[req_q.node] <= 1'b1;
				if (!pv_q[grp_hb]) begin
					pv_q[grp_hb] <= 1'b1;
				end
			end
			if (cmd.eval) begin
				alive_q[idx_q] <= !dead;
			end
			res_v_q <= 1'b0;
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
				res_v_q  <= pend_v_q;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
				res_v_q  <= pend_v_q;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= req;
			idx_q     <= '0;
			mag_q     <= mag_in;
			rem_q     <= '0;
			mod_cnt_q <= '0;
		end
		if (cmd.hb_write) begin
			stamp_q[req_q.node] <= req_q.now;
			load_q[req_q.node]  <= req_q.load;
			if (!pv_q[grp_hb]) begin
				pn_q[grp_hb] <= req_q.node;
			end
		end
		if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.mod_step) begin
			rem_q     <= rem_n[2:0];
			mag_q     <= {mag_q[30:0], 1'b0};
			mod_cnt_q <= mod_cnt_q + 1'b1;
		end
		if (cmd.tgt_node) begin
			tgt_q <= grp_i;
		end else if (cmd.tgt_rem) begin
			tgt_q <= rem_q;
		end
		if (cmd.scan_clr) begin
			scan_q  <= '0;
			best_q  <= max_load_q;
			found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (alive_q[scan_q] && (grp_j == tgt_q) && (load_q[scan_q] < best_q)) begin
				best_q  <= load_q[scan_q];
				pick_q  <= scan_q;
				found_q <= 1'b1;
			end
		end
		if (cmd.set_primary) begin
			pn_q[tgt_q] <= pick_q;
		end
		if (cmd.emit) begin
			pend_q <= new_res;
			res_q  <= pend_q;
		end else if (cmd.flush) begin
			res_q <= '{kind: pend_q.kind, node_out: pend_q.node_out,
				alive_out: pend_q.alive_out, group_out: pend_q.group_out, last: 1'b1};
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

endmodule

/* hw/rtl/node_failover_least_load_picker.sv */
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low. Results come one per
// result_valid pulse, each for exactly one cycle, with last set on the final
// one; the receiver cannot stall them. Results pass through a pending and an
// output register, so the final result of a request is on the ports in the
// cycle in which busy falls, which may be the cycle in which the next request
// is taken. A monitor tick walks the 16 node entries in a sequencer, with a
// primary failover for each dead primary, whose least-load search reads one
// node entry a cycle. A lookup takes the bit-serial remainder of the hash by
// the group count and then runs the node search. Configuration writes are
// taken at any time but are meant for when the block is idle.
module node_failover_least_load_picker import nflp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  nflp_req_t         req,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              result_valid,
	output nflp_res_t         result
);

	nflp_cmd_t  cmd;
	nflp_stat_t stat;

	nflp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (req.op),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	nflp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg_ready    (cfg_ready),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

/* bench/tb_node_failover_least_load_picker.sv */
`timescale 1ns / 1ps
module tb_node_failover_least_load_picker;
	import nflp_pkg::*;

	typedef struct {
		nflp_req_t rq;
		int        n_typed;
		nflp_res_t res;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	nflp_req_t         req;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              result_valid;
	nflp_res_t         result;

	// predictor copy of the block
	logic [15:0]       m_timeout;
	logic [15:0]       m_max_load;
	logic [3:0]        m_group_count;
	logic [CFG_W-1:0]  m_node_groups;
	logic              m_report;
	logic              m_known [NODES];
	logic              m_alive [NODES];
	logic [31:0]       m_stamp [NODES];
	logic [15:0]       m_load [NODES];
	logic              m_prim_valid [GROUPS];
	logic [3:0]        m_prim_node [GROUPS];

	nflp_res_t         pending_results[$];
	stim_row_t         directed[$];
	int                errors = 0;
	int                cycles = 0;
	int                requests_sent = 0;
	int                results_seen = 0;
	logic [31:0]       clock_now = 0;
	bit                allow_gaps = 1;

	node_failover_least_load_picker DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .result(result)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("tb_node_failover_least_load_picker: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		nflp_res_t e;
		if (arst_n && result_valid) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result kind=%0d node=%0d", result.kind, result.node_out);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (result.kind !== e.kind) begin
					$error("kind: expected %0d actual %0d", e.kind, result.kind);
					errors++;
				end
				if (result.node_out !== e.node_out) begin
					$error("node_out: expected %0d actual %0d", e.node_out, result.node_out);
					errors++;
				end
				if (result.alive_out !== e.alive_out) begin
					$error("alive_out: expected %0d actual %0d", e.alive_out, result.alive_out);
					errors++;
				end
				if (result.group_out !== e.group_out) begin
					$error("group_out: expected %0d actual %0d", e.group_out, result.group_out);
					errors++;
				end
				if (result.last !== e.last) begin
					$error("last: expected %0d actual %0d", e.last, result.last);
					errors++;
				end
			end
		end
	end

	function automatic int least_loaded(int g);
		logic [15:0] best;
		int pick;
		best = m_max_load;
		pick = -1;
		for (int i = 0; i < NODES; i++)
			if (m_alive[i] && int'(m_node_groups[3*i +: 3]) == g && m_load[i] < best) begin
				best = m_load[i];
				pick = i;
			end
		return pick;
	endfunction

	function automatic nflp_res_t mk_res(logic [1:0] k, int nd, logic alv, int g);
		nflp_res_t r;
		r.kind = k;
		r.node_out = nd[3:0];
		r.alive_out = alv;
		r.group_out = g[2:0];
		r.last = 0;
		return r;
	endfunction

	task automatic predict(input nflp_req_t r, ref nflp_res_t outq[$]);
		int g, c, gc;
		longint age;
		logic [31:0] mag;
		if (r.op == OP_HEARTBEAT) begin
			m_known[r.node] = 1;
			m_alive[r.node] = 1;
			m_stamp[r.node] = r.now;
			m_load[r.node] = r.load;
			g = int'(m_node_groups[3*r.node +: 3]);
			if (!m_prim_valid[g]) begin
				m_prim_valid[g] = 1;
				m_prim_node[g] = r.node;
				outq.push_back(mk_res(KIND_ASSIGN, r.node, 0, g));
			end
		end else if (r.op == OP_TICK) begin
			for (int i = 0; i < NODES; i++) begin
				if (!m_known[i])
					continue;
				age = longint'({32'b0, r.now}) - longint'({32'b0, m_stamp[i]});
				m_alive[i] = !(age > longint'(m_timeout));
				g = int'(m_node_groups[3*i +: 3]);
				if (m_prim_valid[g] && m_prim_node[g] == i && !m_alive[i]) begin
					c = least_loaded(g);
					if (c < 0)
						continue;
					m_prim_node[g] = c[3:0];
					outq.push_back(mk_res(KIND_ASSIGN, c, 0, g));
				end
				if (m_report)
					outq.push_back(mk_res(KIND_REPORT, i, m_alive[i], 0));
			end
		end else if (r.op == OP_LOOKUP) begin
			gc = int'(m_group_count);
			if (gc == 0)
				gc = 1;
			if (gc > GROUPS)
				gc = GROUPS;
			mag = r.user_hash[31] ? 32'(-r.user_hash) : r.user_hash;
			g = int'(mag % gc);
			c = least_loaded(g);
			if (c < 0)
				outq.push_back(mk_res(KIND_NONE, 0, 0, g));
			else
				outq.push_back(mk_res(KIND_REDIRECT, c, 0, g));
		end
		if (outq.size() > 0)
			outq[outq.size()-1].last = 1;
	endtask

	task automatic send(input nflp_req_t r, input int n_typed, input nflp_res_t typed);
		nflp_res_t got[$];
		@(negedge clk);
		start <= 1;
		req <= r;
		do @(posedge clk); while (busy);
		predict(r, got);
		requests_sent++;
		if (n_typed >= 0) begin
			if (n_typed == 1)
				pending_results.push_back(typed);
		end else
			foreach (got[i]) pending_results.push_back(got[i]);
		if (allow_gaps && $urandom_range(0, 2) == 0) begin
			@(negedge clk);
			start <= 0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 0;
		while (pending_results.size() != 0 || busy) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TIMEOUT:  m_timeout = d[15:0];
			CFG_MAX_LOAD: m_max_load = d[15:0];
			CFG_GROUPS:   m_group_count = d[3:0];
			CFG_NODE_GRP: m_node_groups = d;
			CFG_REPORT:   m_report = d[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic void add_row(logic [1:0] op, int nd, logic [15:0] ld, logic [31:0] t,
			logic [31:0] h, int n, logic [1:0] k, int nout, int g);
		stim_row_t s;
		s.rq = '{op: op, node: nd[3:0], load: ld, now: t, user_hash: h};
		s.n_typed = n;
		s.res = mk_res(k, nout, 0, g);
		s.res.last = 1;
		directed.push_back(s);
	endfunction

	function automatic nflp_req_t rand_request(logic [15:0] max_ld);
		nflp_req_t r;
		int p;
		p = $urandom_range(0, 99);
		r.op = p < 45 ? OP_HEARTBEAT : p < 70 ? OP_TICK : p < 95 ? OP_LOOKUP : 2'd3;
		r.node = 4'($urandom);
		r.load = $urandom_range(0, 3) == 0 ? 16'($urandom)
			: 16'($urandom_range(0, max_ld > 20 ? 20 : max_ld));
		if ($urandom_range(0, 19) == 0)
			clock_now = $urandom;
		else
			clock_now += $urandom_range(0, 3);
		r.now = clock_now;
		r.user_hash = $urandom;
		return r;
	endfunction

	initial begin
		logic [15:0] tmo_set [6] = '{16'd0, 16'd65535, 16'd2, 16'd5, 16'd1, 16'd3};
		logic [15:0] ml_set [6] = '{16'd65535, 16'd0, 16'd10, 16'd100, 16'd15, 16'd65535};
		logic [3:0] gc_set [6] = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5};
		nflp_res_t none;
		nflp_req_t r;
		arst_n = 0;
		start = 0;
		req = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		none = '0;
		m_timeout = 4;
		m_max_load = 100;
		m_group_count = 1;
		m_node_groups = '0;
		m_report = 0;
		for (int i = 0; i < NODES; i++) begin
			m_known[i] = 0;
			m_alive[i] = 0;
		end
		for (int i = 0; i < GROUPS; i++)
			m_prim_valid[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		add_row(OP_LOOKUP, 0, 0, 0, 32'd0, 1, KIND_NONE, 0, 0);
		add_row(OP_HEARTBEAT, 0, 5, 10, 0, 1, KIND_ASSIGN, 0, 0);
		add_row(OP_HEARTBEAT, 1, 0, 10, 0, 0, KIND_REPORT, 0, 0);
		add_row(OP_HEARTBEAT, 15, 16'hFFFF, 10, 0, 0, KIND_REPORT, 0, 0);
		add_row(OP_LOOKUP, 0, 0, 0, 32'h80000000, 1, KIND_REDIRECT, 1, 0);
		add_row(OP_LOOKUP, 0, 0, 0, 32'h7FFFFFFF, 1, KIND_REDIRECT, 1, 0);
		add_row(OP_LOOKUP, 0, 0, 0, 32'hFFFFFFFF, 1, KIND_REDIRECT, 1, 0);
		add_row(OP_TICK, 0, 0, 14, 0, 0, KIND_REPORT, 0, 0);
		add_row(OP_TICK, 0, 0, 15, 0, -1, KIND_REPORT, 0, 0);
		add_row(OP_TICK, 0, 0, 0, 0, -1, KIND_REPORT, 0, 0);
		add_row(2'd3, 5, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, KIND_REPORT, 0, 0);
		add_row(OP_HEARTBEAT, 7, 99, 32'hFFFFFFFF, 0, -1, KIND_REPORT, 0, 0);
		add_row(OP_HEARTBEAT, 8, 100, 32'hFFFFFFFF, 0, -1, KIND_REPORT, 0, 0);
		add_row(OP_TICK, 0, 0, 32'hFFFFFFFF, 0, -1, KIND_REPORT, 0, 0);
		add_row(OP_LOOKUP, 0, 0, 0, 32'h12345678, -1, KIND_REPORT, 0, 0);
		add_row(OP_HEARTBEAT, 3, 16'h5555, 32'hAAAAAAAA, 0, -1, KIND_REPORT, 0, 0);
		add_row(OP_TICK, 0, 0, 32'h55555555, 0, -1, KIND_REPORT, 0, 0);
		add_row(OP_LOOKUP, 0, 0, 0, 32'h80000001, -1, KIND_REPORT, 0, 0);
		foreach (directed[i])
			send(directed[i].rq, directed[i].n_typed, directed[i].res);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			cfg_write(CFG_TIMEOUT, CFG_W'(tmo_set[ph]));
			cfg_write(CFG_MAX_LOAD, CFG_W'(ml_set[ph]));
			cfg_write(CFG_GROUPS, CFG_W'(gc_set[ph]));
			if (ph == 0)
				cfg_write(CFG_NODE_GRP, {CFG_W{1'b1}});
			else if (ph == 1)
				cfg_write(CFG_NODE_GRP, '0);
			else
				cfg_write(CFG_NODE_GRP,
					CFG_W'({$urandom, $urandom} & 64'h0000_6DB6_DB6D_B6DB));
			cfg_write(CFG_REPORT, CFG_W'(ph % 2 == 0));
			if (ph == 5)
				allow_gaps = 0;
			for (int k = 0; k < 40; k++) begin
				r = rand_request(m_max_load);
				send(r, -1, none);
			end
		end

		wait_idle();
		$display("sent %0d requests under 7 register settings", requests_sent);
		$display("checked %0d results against the predictor", results_seen);
		if (errors == 0)
			$display("tb_node_failover_least_load_picker: clean");
		else
			$display("tb_node_failover_least_load_picker: errors");
		$finish;
	end

endmodule

/* node_failover_least_load_picker.f */
hw/rtl/nflp_pkg.sv
hw/rtl/nflp_ctrl.sv
hw/rtl/nflp_dp.sv
hw/rtl/node_failover_least_load_picker.sv
bench/tb_node_failover_least_load_picker.sv
